@@ design/jms_pkg.sv @@
// ---------------------------------------------------------------------------
// jms_pkg
// Shared types and constants for the JPEG marker scanner.
// ---------------------------------------------------------------------------
package jms_pkg;

  localparam int POS_BITS  = 24;
  localparam int SIZE_BITS = 24;
  localparam int LEN_BITS  = 24;
  localparam int DIM_BITS  = 16;
  localparam int CMP_BITS  = POS_BITS + 2;

  localparam logic [SIZE_BITS-1:0] BUFFER_SIZE_RESET = '1;

  localparam logic [7:0] MK_FF   = 8'hFF;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_TEM  = 8'h01;

  localparam logic STATUS_EOI   = 1'b0;
  localparam logic STATUS_NOEOI = 1'b1;

  typedef enum logic [2:0] {
    PH_SCAN   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic                status;
    logic [LEN_BITS-1:0] total_length;
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic                size_found;
  } result_t;

endpackage

@@ design/jms_parser.sv @@
// ---------------------------------------------------------------------------
// jms_parser
// Input word register and marker parse state; one word processed per cycle while the result queue is not full.
// ---------------------------------------------------------------------------
module jms_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [jms_pkg::SIZE_BITS-1:0] buffer_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  input  logic                          res_full,
  output logic                          res_valid,
  output jms_pkg::result_t              res
);

  logic       ivalid;
  logic [7:0] ibyte;
  logic       ifirst;
  logic       accept;
  logic       consume;

  jms_pkg::phase_t              phase, phase_next, cur_phase;
  logic [jms_pkg::POS_BITS-1:0] pos, pos_next, cur_pos;
  logic                         prev_ff, prev_ff_next, cur_prev_ff;
  logic [jms_pkg::POS_BITS-1:0] mpos, mpos_next, cur_mpos;
  logic [7:0]                   code, code_next, cur_code;
  logic [15:0]                  seglen, seglen_next, cur_seglen;
  logic [15:0]                  skip, skip_next, cur_skip;
  logic [2:0]                   poff, poff_next, cur_poff;
  logic [jms_pkg::DIM_BITS-1:0] wid, wid_next, cur_wid;
  logic [jms_pkg::DIM_BITS-1:0] hgt, hgt_next, cur_hgt;
  logic                         sof, sof_next, cur_sof;
  logic                         fin, fin_next, cur_fin;

  logic                         take;
  logic [jms_pkg::POS_BITS-1:0] take_pos;
  logic [jms_pkg::CMP_BITS-1:0] pos_sum;
  logic [jms_pkg::CMP_BITS-1:0] seg_end;
  logic [15:0]                  len;
  logic                         over;
  logic                         emit;
  jms_pkg::result_t             res_w;

  assign in_stall = ivalid && res_full;
  assign accept   = in_valid && !in_stall;
  assign consume  = ivalid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (accept) begin
      ivalid <= 1'b1;
    end else if (consume) begin
      ivalid <= 1'b0;
    end
    if (accept) begin
      ibyte  <= data_byte;
      ifirst <= first_byte;
    end
  end

  // start of a new buffer clears the parse state
  always_comb begin
    if (ifirst) begin
      cur_phase   = jms_pkg::PH_SCAN;
      cur_pos     = '0;
      cur_prev_ff = 1'b0;
      cur_mpos    = '0;
      cur_code    = '0;
      cur_seglen  = '0;
      cur_skip    = '0;
      cur_poff    = '0;
      cur_wid     = '0;
      cur_hgt     = '0;
      cur_sof     = 1'b0;
      cur_fin     = 1'b0;
    end else begin
      cur_phase   = phase;
      cur_pos     = pos;
      cur_prev_ff = prev_ff;
      cur_mpos    = mpos;
      cur_code    = code;
      cur_seglen  = seglen;
      cur_skip    = skip;
      cur_poff    = poff;
      cur_wid     = wid;
      cur_hgt     = hgt;
      cur_sof     = sof;
      cur_fin     = fin;
    end
  end

  assign pos_sum = jms_pkg::CMP_BITS'(cur_pos) + jms_pkg::CMP_BITS'(1);
  assign len     = {cur_seglen[15:8], ibyte};
  assign seg_end = jms_pkg::CMP_BITS'(cur_mpos) + jms_pkg::CMP_BITS'(2)
                 + jms_pkg::CMP_BITS'(len);
  assign over    = seg_end > jms_pkg::CMP_BITS'(buffer_size);

  always_comb begin
    phase_next   = cur_phase;
    pos_next     = cur_pos;
    prev_ff_next = cur_prev_ff;
    mpos_next    = cur_mpos;
    code_next    = cur_code;
    seglen_next  = cur_seglen;
    skip_next    = cur_skip;
    poff_next    = cur_poff;
    wid_next     = cur_wid;
    hgt_next     = cur_hgt;
    sof_next     = cur_sof;
    fin_next     = cur_fin;
    take         = 1'b0;
    take_pos     = cur_pos - jms_pkg::POS_BITS'(1);
    emit         = 1'b0;
    res_w        = '0;
    if (!cur_fin) begin
      pos_next = pos_sum[jms_pkg::POS_BITS-1:0];
      unique case (cur_phase)
        jms_pkg::PH_SCAN: begin
          if (cur_prev_ff && ibyte != 8'h00) begin
            take = 1'b1;
          end else begin
            prev_ff_next = (ibyte == jms_pkg::MK_FF);
          end
        end
        jms_pkg::PH_LEN_HI: begin
          seglen_next = {ibyte, 8'h00};
          phase_next  = jms_pkg::PH_LEN_LO;
        end
        jms_pkg::PH_LEN_LO: begin
          seglen_next = len;
          if (!over && len >= 16'd2) begin
            if (len == 16'd2) begin
              phase_next   = jms_pkg::PH_SCAN;
              prev_ff_next = 1'b0;
            end else begin
              skip_next  = len - 16'd2;
              poff_next  = '0;
              phase_next = jms_pkg::PH_SKIP;
            end
          end else if (!over && len == 16'd1) begin
            phase_next   = jms_pkg::PH_SCAN;
            prev_ff_next = (ibyte == jms_pkg::MK_FF);
          end else if (cur_seglen[15:8] == jms_pkg::MK_FF && ibyte != 8'h00) begin
            take = 1'b1;
          end else begin
            phase_next   = jms_pkg::PH_SCAN;
            prev_ff_next = (ibyte == jms_pkg::MK_FF);
          end
        end
        jms_pkg::PH_SKIP: begin
          if (cur_code == jms_pkg::MK_SOF0) begin
            case (cur_poff)
              3'd1:    hgt_next[15:8] = ibyte;
              3'd2:    hgt_next[7:0]  = ibyte;
              3'd3:    wid_next[15:8] = ibyte;
              3'd4: begin
                wid_next[7:0] = ibyte;
                sof_next      = 1'b1;
              end
              default: ;
            endcase
          end
          if (cur_poff != 3'd7) begin
            poff_next = cur_poff + 3'd1;
          end
          skip_next = cur_skip - 16'd1;
          if (skip_next == 16'd0) begin
            phase_next   = jms_pkg::PH_SCAN;
            prev_ff_next = 1'b0;
          end
        end
        default: begin
          phase_next   = jms_pkg::PH_SCAN;
          prev_ff_next = 1'b0;
        end
      endcase

      if (take) begin
        prev_ff_next = 1'b0;
        if (ibyte == jms_pkg::MK_EOI) begin
          emit               = 1'b1;
          res_w.status       = jms_pkg::STATUS_EOI;
          res_w.total_length = pos_sum[jms_pkg::LEN_BITS-1:0];
        end else if (ibyte == jms_pkg::MK_SOI || ibyte == jms_pkg::MK_TEM ||
                     (ibyte >= jms_pkg::MK_RST0 && ibyte <= jms_pkg::MK_RST7)) begin
          phase_next = jms_pkg::PH_SCAN;
        end else begin
          mpos_next  = take_pos;
          code_next  = ibyte;
          phase_next = jms_pkg::PH_LEN_HI;
        end
      end

      // last byte of the buffer without end of image
      if (!emit && pos_sum >= jms_pkg::CMP_BITS'(buffer_size)) begin
        emit               = 1'b1;
        res_w.status       = jms_pkg::STATUS_NOEOI;
        res_w.total_length = '0;
      end

      if (emit) begin
        fin_next           = 1'b1;
        phase_next         = jms_pkg::PH_DONE;
        res_w.frame_width  = wid_next;
        res_w.frame_height = hgt_next;
        res_w.size_found   = sof_next;
      end
    end
  end

  assign res_valid = consume && emit;
  assign res       = res_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= jms_pkg::PH_SCAN;
      pos     <= '0;
      prev_ff <= 1'b0;
      mpos    <= '0;
      code    <= '0;
      seglen  <= '0;
      skip    <= '0;
      poff    <= '0;
      wid     <= '0;
      hgt     <= '0;
      sof     <= 1'b0;
      fin     <= 1'b0;
    end else if (consume) begin
      phase   <= phase_next;
      pos     <= pos_next;
      prev_ff <= prev_ff_next;
      mpos    <= mpos_next;
      code    <= code_next;
      seglen  <= seglen_next;
      skip    <= skip_next;
      poff    <= poff_next;
      wid     <= wid_next;
      hgt     <= hgt_next;
      sof     <= sof_next;
      fin     <= fin_next;
    end
  end

endmodule

@@ design/jms_out_fifo.sv @@
// ---------------------------------------------------------------------------
// jms_out_fifo
// Two-entry result queue between the parser and the output channel.
// ---------------------------------------------------------------------------
module jms_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jms_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output jms_pkg::result_t out_data
);

  jms_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/jpeg_marker_scanner_top.sv @@
// ---------------------------------------------------------------------------
// jpeg_marker_scanner_top
// Byte-serial JPEG marker scanner reporting image size and length at EOI.
// ---------------------------------------------------------------------------
// path: each input word is registered, parsed combinationally and written into the result queue
// throughput: one word per cycle while the result queue is not full; the parse step is combinational
// a two-entry result queue keeps input flowing while a result is stalled, until the queue is full
// reset: synchronous, clears parse state and queue, buffer_size to all ones
module jpeg_marker_scanner_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [jms_pkg::SIZE_BITS-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [jms_pkg::LEN_BITS-1:0]  total_length,
  output logic [jms_pkg::DIM_BITS-1:0]  frame_width,
  output logic [jms_pkg::DIM_BITS-1:0]  frame_height,
  output logic                          size_found
);

  logic [jms_pkg::SIZE_BITS-1:0] buffer_size;
  logic                          res_valid;
  logic                          res_full;
  jms_pkg::result_t              res;
  jms_pkg::result_t              out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= jms_pkg::BUFFER_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size <= cfg_wr_data;
    end
  end

  jms_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .buffer_size (buffer_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .res_full    (res_full),
    .res_valid   (res_valid),
    .res         (res)
  );

  jms_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (res_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status       = out_data.status;
  assign total_length = out_data.total_length;
  assign frame_width  = out_data.frame_width;
  assign frame_height = out_data.frame_height;
  assign size_found   = out_data.size_found;

endmodule
